// ----- rtl/core/c8x_pkg.sv -----
// Shared types, constants and decode helpers for the CHIP-8 execute block.
package c8x_pkg;

  localparam int MEM_BYTES   = 4096;
  localparam int SCREEN_W    = 64;
  localparam int SCREEN_H    = 32;
  localparam int STACK_DEPTH = 16;

  localparam int MEM_AW = $clog2(MEM_BYTES);
  localparam int ROW_AW = $clog2(SCREEN_H);
  localparam int COL_AW = $clog2(SCREEN_W);
  localparam int SP_W   = $clog2(STACK_DEPTH);

  localparam logic [MEM_AW-1:0] START_PC   = 12'h200;
  localparam logic [MEM_AW-1:0] FONT_BYTES = 12'd80;
  localparam logic [3:0]        REG_VF     = 4'hF;

  localparam logic [1:0] FN_LOAD  = 2'd0;
  localparam logic [1:0] FN_EXEC  = 2'd1;
  localparam logic [1:0] FN_TICK  = 2'd2;
  localparam logic [1:0] FN_PIXEL = 2'd3;

  localparam logic [7:0] FONT_ROM [80] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  typedef enum logic [4:0] {
    CL_SYS, CL_CLS, CL_RET, CL_JP, CL_CALL, CL_SE, CL_SNE, CL_LDK, CL_ADDK,
    CL_MOV, CL_AND, CL_ADDC, CL_SUB, CL_LDI, CL_RND, CL_DRW, CL_SKNP,
    CL_GETDT, CL_SETDT, CL_SETST, CL_ADDI, CL_FONT, CL_BCD, CL_LDM, CL_BAD
  } cls_t;

  typedef enum logic [14:0] {
    ST_CLR  = 15'h0001,
    ST_IDLE = 15'h0002,
    ST_FHI  = 15'h0004,
    ST_FLO  = 15'h0008,
    ST_RD   = 15'h0010,
    ST_EX   = 15'h0020,
    ST_W2   = 15'h0040,
    ST_CLS  = 15'h0080,
    ST_BCD  = 15'h0100,
    ST_LDM  = 15'h0200,
    ST_DRA  = 15'h0400,
    ST_DRB  = 15'h0800,
    ST_DRV  = 15'h1000,
    ST_PIX  = 15'h2000,
    ST_DONE = 15'h4000
  } state_t;

  typedef struct packed {
    state_t st;
    cls_t   cls;
    logic   accept;
  } c8x_cmd_t;

  typedef struct packed {
    logic [15:0]       op;
    logic [MEM_AW-1:0] cnt;
    logic              out_busy;
  } c8x_sts_t;

  function automatic logic [7:0] font_byte(input logic [MEM_AW-1:0] a);
    logic [7:0] b;
    b = 8'h00;
    if (a < FONT_BYTES) b = FONT_ROM[a[6:0]];
    return b;
  endfunction

  function automatic cls_t c8x_decode(input logic [15:0] op);
    cls_t c;
    c = CL_BAD;
    case (op[15:12])
      4'h0: begin
        case (op[7:0])
          8'h00:   c = CL_SYS;
          8'hE0:   c = CL_CLS;
          8'hEE:   c = CL_RET;
          default: c = CL_BAD;
        endcase
      end
      4'h1: c = CL_JP;
      4'h2: c = CL_CALL;
      4'h3: c = CL_SE;
      4'h4: c = CL_SNE;
      4'h6: c = CL_LDK;
      4'h7: c = CL_ADDK;
      4'h8: begin
        case (op[3:0])
          4'h0:    c = CL_MOV;
          4'h2:    c = CL_AND;
          4'h4:    c = CL_ADDC;
          4'h5:    c = CL_SUB;
          default: c = CL_BAD;
        endcase
      end
      4'hA: c = CL_LDI;
      4'hC: c = CL_RND;
      4'hD: c = CL_DRW;
      4'hE: c = CL_SKNP;
      4'hF: begin
        case (op[7:0])
          8'h07:   c = CL_GETDT;
          8'h15:   c = CL_SETDT;
          8'h18:   c = CL_SETST;
          8'h1E:   c = CL_ADDI;
          8'h29:   c = CL_FONT;
          8'h33:   c = CL_BCD;
          8'h65:   c = CL_LDM;
          default: c = CL_BAD;
        endcase
      end
      default: c = CL_BAD;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/core/c8x_ctrl.sv -----
// Sequencing state machine for the CHIP-8 execute block.
module c8x_ctrl import c8x_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_func,
  input  c8x_sts_t   sts,
  output c8x_cmd_t   cmd,
  output logic       in_stall
);

  state_t     state_r, state_nxt;
  cls_t       cls;
  logic [3:0] opx, opn;
  logic       accept;

  assign cls      = c8x_decode(sts.op);
  assign opx      = sts.op[11:8];
  assign opn      = sts.op[3:0];
  assign accept   = (state_r == ST_IDLE) && in_valid;
  assign in_stall = (state_r != ST_IDLE);

  assign cmd.st     = state_r;
  assign cmd.cls    = cls;
  assign cmd.accept = accept;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLR:  if (sts.cnt == MEM_AW'(MEM_BYTES - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) begin
          case (in_func)
            FN_EXEC:  state_nxt = ST_FHI;
            FN_PIXEL: state_nxt = ST_PIX;
            default:  state_nxt = ST_DONE;
          endcase
        end
      end
      ST_FHI:  state_nxt = ST_FLO;
      ST_FLO:  state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_EX;
      ST_EX: begin
        case (cls)
          CL_CLS:          state_nxt = ST_CLS;
          CL_ADDC, CL_SUB: state_nxt = ST_W2;
          CL_BCD:          state_nxt = ST_BCD;
          CL_LDM:          state_nxt = (opx == 4'h0) ? ST_DONE : ST_LDM;
          CL_DRW:          state_nxt = (opn == 4'h0) ? ST_DRV : ST_DRA;
          default:         state_nxt = ST_DONE;
        endcase
      end
      ST_W2:   state_nxt = ST_DONE;
      ST_CLS:  if (sts.cnt[ROW_AW-1:0] == ROW_AW'(SCREEN_H - 1)) state_nxt = ST_DONE;
      ST_BCD:  if (sts.cnt[1:0] == 2'd2) state_nxt = ST_DONE;
      ST_LDM:  if (sts.cnt[3:0] == opx) state_nxt = ST_DONE;
      ST_DRA:  state_nxt = ST_DRB;
      ST_DRB:  state_nxt = (sts.cnt[3:0] == opn - 4'd1) ? ST_DRV : ST_DRA;
      ST_DRV:  state_nxt = ST_DONE;
      ST_PIX:  state_nxt = ST_DONE;
      ST_DONE: if (!sts.out_busy) state_nxt = ST_IDLE;
      default: state_nxt = ST_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> state_r == ST_CLR)
    else $error("reset did not start the clearing sweep");
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != ST_IDLE)
    else $error("accepted item did not start work");
  a_done_releases: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !sts.out_busy) |=> state_r == ST_IDLE)
    else $error("result stage did not release");
  a_draw_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DRB |-> $past(state_r) == ST_DRA)
    else $error("sprite row write without a row read");

endmodule

// ----- rtl/core/c8x_dpath.sv -----
// Datapath of the CHIP-8 execute block: registers, memories, frame buffer, result stage.
module c8x_dpath import c8x_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  c8x_cmd_t    cmd,
  output c8x_sts_t    sts,
  input  logic [1:0]  in_func,
  input  logic [11:0] in_address,
  input  logic [7:0]  in_data_byte,
  input  logic [15:0] in_key_mask,
  input  logic [7:0]  in_random_byte,
  input  logic [10:0] in_pixel_index,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [11:0] out_pc,
  output logic [15:0] out_opcode,
  output logic        out_draw_flag,
  output logic        out_beep,
  output logic        out_unknown_opcode,
  output logic        out_pixel
);

  // storage
  logic [7:0]          mem_r   [MEM_BYTES];
  logic [7:0]          rf_r    [16];
  logic [SCREEN_W-1:0] fb_r    [SCREEN_H];
  logic [MEM_AW-1:0]   stack_r [STACK_DEPTH];

  logic [7:0]          mem_q_r, rf_qa_r, rf_qb_r;
  logic [SCREEN_W-1:0] fb_q_r;

  logic [MEM_AW-1:0] mem_ra, mem_wa;
  logic              mem_we;
  logic [7:0]        mem_wd;
  logic [3:0]        rf_ra_a, rf_ra_b, rf_wa;
  logic              rf_we;
  logic [7:0]        rf_wd;
  logic [ROW_AW-1:0] fb_ra, fb_wa;
  logic              fb_we;
  logic [SCREEN_W-1:0] fb_wd;
  logic              stk_we;

  logic [MEM_AW-1:0] pc_r, pc_nxt;
  logic [15:0]       i_r, i_nxt;
  logic [SP_W-1:0]   sp_r, sp_nxt;
  logic [7:0]        dt_r, dt_nxt, snd_r, snd_nxt;
  logic [MEM_AW-1:0] cnt_r, cnt_nxt;
  logic [15:0]       op_r, op_nxt;
  logic [7:0]        op_hi_r, op_hi_nxt;
  logic [7:0]        tmp_r, tmp_nxt, vx_r, vx_nxt, vy_r, vy_nxt;
  logic              coll_r, coll_nxt;
  logic [15:0]       keys_r, keys_nxt;
  logic [7:0]        rnd_r, rnd_nxt;
  logic [10:0]       pidx_r, pidx_nxt;
  logic              unk_r, unk_nxt, drew_r, drew_nxt, beep_r, beep_nxt, pix_r, pix_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [11:0]       out_pc_r;
  logic [15:0]       out_op_r;
  logic              out_drew_r, out_beep_r, out_unk_r, out_pix_r;

  logic [3:0]        opx, opy;
  logic [7:0]        kk, vx, vy;
  logic [11:0]       nnn;
  logic [MEM_AW-1:0] pc_next2, pc_skip;
  logic [8:0]        sum9;
  logic [7:0]        vf_add, vf_sub;
  logic [SCREEN_W-1:0] spr_base, spr_mask;
  logic [2*SCREEN_W-1:0] spr_rot;
  logic [1:0]        bcd_h;
  logic [6:0]        bcd_rem;
  logic [14:0]       bcd_prod;
  logic [3:0]        bcd_t, bcd_o;
  logic [7:0]        bcd_digit;
  logic              out_busy;

  assign opx      = op_r[11:8];
  assign opy      = op_r[7:4];
  assign kk       = op_r[7:0];
  assign nnn      = op_r[11:0];
  assign vx       = rf_qa_r;
  assign vy       = rf_qb_r;
  assign pc_next2 = pc_r + MEM_AW'(2);
  assign pc_skip  = pc_r + MEM_AW'(4);
  assign sum9     = {1'b0, vx} + {1'b0, vy};
  // flag is written first, so a VF operand of 8xy4/8xy5 sees the new flag
  assign vf_add   = {7'b0, sum9[8]};
  assign vf_sub   = {7'b0, (vx > vy)};
  assign out_busy = out_valid_r && out_stall;

  assign sts.op       = op_r;
  assign sts.cnt      = cnt_r;
  assign sts.out_busy = out_busy;

  // sprite row placed at its column with wrap: screen bit c is column c
  always_comb begin
    spr_base = '0;
    for (int c = 0; c < 8; c++) spr_base[c] = mem_q_r[7-c];
  end
  assign spr_rot  = {spr_base, spr_base} << vx_r[COL_AW-1:0];
  assign spr_mask = spr_rot[2*SCREEN_W-1:SCREEN_W];

  // BCD digits of vx_r; tens by reciprocal multiply, exact below 100
  always_comb begin
    bcd_h    = (vx_r >= 8'd200) ? 2'd2 : ((vx_r >= 8'd100) ? 2'd1 : 2'd0);
    bcd_rem  = 7'(vx_r - 8'(bcd_h) * 8'd100);
    bcd_prod = 15'(bcd_rem) * 15'd205;
    bcd_t    = bcd_prod[14:11];
    bcd_o    = 4'(bcd_rem - 7'(bcd_t) * 7'd10);
    case (cnt_r[1:0])
      2'd0:    bcd_digit = {6'b0, bcd_h};
      2'd1:    bcd_digit = {4'b0, bcd_t};
      default: bcd_digit = {4'b0, bcd_o};
    endcase
  end

  always_comb begin
    mem_ra = pc_r;  mem_we = 1'b0; mem_wa = in_address; mem_wd = in_data_byte;
    rf_ra_a = opx;  rf_ra_b = opy; rf_we = 1'b0; rf_wa = opx; rf_wd = 8'h00;
    fb_ra = in_pixel_index[10:COL_AW]; fb_we = 1'b0;
    fb_wa = cnt_r[ROW_AW-1:0]; fb_wd = '0;
    stk_we = 1'b0;
    pc_nxt = pc_r; i_nxt = i_r; sp_nxt = sp_r; dt_nxt = dt_r; snd_nxt = snd_r;
    cnt_nxt = cnt_r; op_nxt = op_r; op_hi_nxt = op_hi_r; tmp_nxt = tmp_r;
    vx_nxt = vx_r; vy_nxt = vy_r; coll_nxt = coll_r; keys_nxt = keys_r;
    rnd_nxt = rnd_r; pidx_nxt = pidx_r; unk_nxt = unk_r; drew_nxt = drew_r;
    beep_nxt = beep_r; pix_nxt = pix_r;

    case (cmd.st)
      ST_CLR: begin
        mem_we  = 1'b1;
        mem_wa  = cnt_r;
        mem_wd  = font_byte(cnt_r);
        rf_we   = 1'b1;
        rf_wa   = cnt_r[3:0];
        fb_we   = 1'b1;
        cnt_nxt = cnt_r + MEM_AW'(1);
      end
      ST_IDLE: begin
        if (cmd.accept) begin
          keys_nxt = in_key_mask;
          rnd_nxt  = in_random_byte;
          pidx_nxt = in_pixel_index;
          op_nxt   = 16'h0000;
          unk_nxt  = 1'b0;
          drew_nxt = 1'b0;
          beep_nxt = 1'b0;
          pix_nxt  = 1'b0;
          case (in_func)
            FN_LOAD: mem_we = 1'b1;
            FN_TICK: begin
              dt_nxt   = (dt_r == 8'd0) ? 8'd0 : dt_r - 8'd1;
              snd_nxt  = (snd_r == 8'd0) ? 8'd0 : snd_r - 8'd1;
              beep_nxt = (snd_r == 8'd1);
            end
            default: ;
          endcase
        end
      end
      ST_FHI: begin
        op_hi_nxt = mem_q_r;
        mem_ra    = pc_r + MEM_AW'(1);
      end
      ST_FLO: op_nxt = {op_hi_r, mem_q_r};
      ST_RD: begin
        mem_ra  = i_r[MEM_AW-1:0];
        cnt_nxt = '0;
      end
      ST_EX: begin
        pc_nxt = pc_next2;
        case (cmd.cls)
          CL_SYS, CL_JP: pc_nxt = nnn;
          CL_CLS: cnt_nxt = '0;
          CL_RET: begin
            pc_nxt = stack_r[sp_r];
            sp_nxt = sp_r - SP_W'(1);
          end
          CL_CALL: begin
            sp_nxt = sp_r + SP_W'(1);
            stk_we = 1'b1;
            pc_nxt = nnn;
          end
          CL_SE:  pc_nxt = (vx == kk) ? pc_skip : pc_next2;
          CL_SNE: pc_nxt = (vx != kk) ? pc_skip : pc_next2;
          CL_LDK:  begin rf_we = 1'b1; rf_wd = kk; end
          CL_ADDK: begin rf_we = 1'b1; rf_wd = vx + kk; end
          CL_MOV:  begin rf_we = 1'b1; rf_wd = vy; end
          CL_AND:  begin rf_we = 1'b1; rf_wd = vx & vy; end
          CL_ADDC: begin
            rf_we = 1'b1; rf_wa = REG_VF; rf_wd = vf_add;
            tmp_nxt = ((opx == REG_VF) ? vf_add : vx) + ((opy == REG_VF) ? vf_add : vy);
          end
          CL_SUB: begin
            rf_we = 1'b1; rf_wa = REG_VF; rf_wd = vf_sub;
            tmp_nxt = ((opx == REG_VF) ? vf_sub : vx) - ((opy == REG_VF) ? vf_sub : vy);
          end
          CL_LDI: i_nxt = {4'b0, nnn};
          CL_RND: begin
            rf_we = 1'b1;
            rf_wd = ((rnd_r == 8'hFF) ? 8'h00 : rnd_r) & kk;
          end
          CL_DRW: begin
            drew_nxt = 1'b1; vx_nxt = vx; vy_nxt = vy;
            cnt_nxt = '0; coll_nxt = 1'b0;
          end
          CL_SKNP: pc_nxt = (vx[7:4] == 4'h0 && keys_r[vx[3:0]]) ? pc_next2 : pc_skip;
          CL_GETDT: begin rf_we = 1'b1; rf_wd = dt_r; end
          CL_SETDT: dt_nxt = vx;
          CL_SETST: snd_nxt = vx;
          CL_ADDI:  i_nxt = i_r + {8'b0, vx};
          CL_FONT:  i_nxt = {8'b0, vx} * 16'd5;
          CL_BCD: begin vx_nxt = vx; cnt_nxt = '0; end
          CL_LDM: begin
            rf_we = 1'b1; rf_wa = 4'h0; rf_wd = mem_q_r;
            mem_ra = i_r[MEM_AW-1:0] + MEM_AW'(1);
            cnt_nxt = MEM_AW'(1);
          end
          default: unk_nxt = 1'b1;
        endcase
      end
      ST_W2: begin rf_we = 1'b1; rf_wd = tmp_r; end
      ST_CLS: begin
        fb_we   = 1'b1;
        cnt_nxt = cnt_r + MEM_AW'(1);
      end
      ST_BCD: begin
        mem_we  = 1'b1;
        mem_wa  = i_r[MEM_AW-1:0] + cnt_r;
        mem_wd  = bcd_digit;
        cnt_nxt = cnt_r + MEM_AW'(1);
      end
      ST_LDM: begin
        rf_we   = 1'b1; rf_wa = cnt_r[3:0]; rf_wd = mem_q_r;
        mem_ra  = i_r[MEM_AW-1:0] + cnt_r + MEM_AW'(1);
        cnt_nxt = cnt_r + MEM_AW'(1);
      end
      ST_DRA: begin
        mem_ra = i_r[MEM_AW-1:0] + cnt_r;
        fb_ra  = vy_r[ROW_AW-1:0] + cnt_r[ROW_AW-1:0];
      end
      ST_DRB: begin
        fb_we    = 1'b1;
        fb_wa    = vy_r[ROW_AW-1:0] + cnt_r[ROW_AW-1:0];
        fb_wd    = fb_q_r ^ spr_mask;
        coll_nxt = coll_r | (|(fb_q_r & spr_mask));
        cnt_nxt  = cnt_r + MEM_AW'(1);
      end
      ST_DRV: begin rf_we = 1'b1; rf_wa = REG_VF; rf_wd = {7'b0, coll_r}; end
      ST_PIX: pix_nxt = fb_q_r[pidx_r[COL_AW-1:0]];
      default: ;
    endcase
  end

  assign out_valid_nxt = (cmd.st == ST_DONE && !out_busy) ? 1'b1 :
                         (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (mem_we) mem_r[mem_wa] <= mem_wd;
    mem_q_r <= mem_r[mem_ra];
    if (rf_we) rf_r[rf_wa] <= rf_wd;
    rf_qa_r <= rf_r[rf_ra_a];
    rf_qb_r <= rf_r[rf_ra_b];
    if (fb_we) fb_r[fb_wa] <= fb_wd;
    fb_q_r <= fb_r[fb_ra];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stack_r[sp_nxt] <= pc_next2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= START_PC;
      i_r         <= 16'h0000;
      sp_r        <= '0;
      dt_r        <= 8'h00;
      snd_r       <= 8'h00;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      i_r         <= i_nxt;
      sp_r        <= sp_nxt;
      dt_r        <= dt_nxt;
      snd_r       <= snd_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    op_hi_r <= op_hi_nxt;
    tmp_r   <= tmp_nxt;
    vx_r    <= vx_nxt;
    vy_r    <= vy_nxt;
    coll_r  <= coll_nxt;
    keys_r  <= keys_nxt;
    rnd_r   <= rnd_nxt;
    pidx_r  <= pidx_nxt;
    unk_r   <= unk_nxt;
    drew_r  <= drew_nxt;
    beep_r  <= beep_nxt;
    pix_r   <= pix_nxt;
    if (cmd.st == ST_DONE && !out_busy) begin
      out_pc_r   <= pc_r;
      out_op_r   <= op_r;
      out_drew_r <= drew_r;
      out_beep_r <= beep_r;
      out_unk_r  <= unk_r;
      out_pix_r  <= pix_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pc             = out_pc_r;
  assign out_opcode         = out_op_r;
  assign out_draw_flag      = out_drew_r;
  assign out_beep           = out_beep_r;
  assign out_unknown_opcode = out_unk_r;
  assign out_pixel          = out_pix_r;

endmodule

// ----- rtl/core/chip8_instruction_execute.sv -----
// CHIP-8 execute block top level: controller plus datapath.
// Input channel (in_*): one item per handshake; in_func selects load memory
// byte, execute one instruction, timer tick or read pixel. Result channel
// (out_*): exactly one item per input item, in order, from an output register.
// DRW does one frame-buffer row read and one write per sprite row.
// Items are taken one at a time; in_stall is low only while idle, so the next
// item enters the cycle after the previous result is loaded. Instruction
// fetch takes two reads of the main memory, which has a single read port.
// After reset the block sweeps main memory (font in bytes 0-79, rest zero),
// the register file and the frame buffer with in_stall high.
// If the receiver stalls, the result holds in the output register; the next
// item may still be accepted and runs until its own result is ready, then
// waits for the register to empty.
module chip8_instruction_execute import c8x_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [11:0] in_address,
  input  logic [7:0]  in_data_byte,
  input  logic [15:0] in_key_mask,
  input  logic [7:0]  in_random_byte,
  input  logic [10:0] in_pixel_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_pc,
  output logic [15:0] out_opcode,
  output logic        out_draw_flag,
  output logic        out_beep,
  output logic        out_unknown_opcode,
  output logic        out_pixel
);

  c8x_cmd_t cmd;
  c8x_sts_t sts;

  c8x_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  c8x_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_func            (in_func),
    .in_address         (in_address),
    .in_data_byte       (in_data_byte),
    .in_key_mask        (in_key_mask),
    .in_random_byte     (in_random_byte),
    .in_pixel_index     (in_pixel_index),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_pc             (out_pc),
    .out_opcode         (out_opcode),
    .out_draw_flag      (out_draw_flag),
    .out_beep           (out_beep),
    .out_unknown_opcode (out_unknown_opcode),
    .out_pixel          (out_pixel)
  );

endmodule
